// ----- rtl/ols_pkg.sv -----
// Shared types and constants for the ordered list store.
// Used by ols_cell, ols_ctrl and ordered_list_search_delete; depends on nothing.
`timescale 1ns / 1ps

package ols_pkg;

    localparam int CAPACITY_DEFAULT = 16;

    localparam int DATA_W     = 32;
    localparam int REQ_W      = 2;
    localparam int STATUS_W   = 3;
    localparam int LEN_W      = 5;
    localparam int OUT_DATA_W = 8;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT  = 2'd0,
        REQ_SEARCH  = 2'd1,
        REQ_DELETE  = 2'd2,
        REQ_REVERSE = 2'd3
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_DONE      = 3'd0,
        STS_FOUND     = 3'd1,
        STS_NOT_FOUND = 3'd2,
        STS_EMPTY     = 3'd3,
        STS_FULL      = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_PUSH   = 2'd1,
        CELL_APPEND = 2'd2,
        CELL_CLOSE  = 2'd3
    } cell_op_t;

    typedef enum logic [1:0] {
        HIT_HOLD  = 2'd0,
        HIT_LOAD  = 2'd1,
        HIT_SHIFT = 2'd2
    } hit_op_t;

    typedef struct packed {
        cell_op_t op;
        hit_op_t  hit_op;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_SCAN   = 2'd1,
        ST_COMMIT = 2'd2
    } state_t;

endpackage

// ----- rtl/ols_cell.sv -----
// One storage cell of the list chain: an entry and its match bit.
// Depends on ols_pkg.
`timescale 1ns / 1ps

module ols_cell #(
    parameter int CW    = 5,
    parameter int INDEX = 0
) (
    input  logic                         clk,
    input  ols_pkg::cell_ctrl_t          ctrl,
    input  logic [CW-1:0]                count,
    input  logic [CW-1:0]                pos,
    input  logic [ols_pkg::DATA_W-1:0]   value,
    input  logic [ols_pkg::DATA_W-1:0]   below_entry,
    input  logic [ols_pkg::DATA_W-1:0]   above_entry,
    input  logic                         above_hit,
    output logic [ols_pkg::DATA_W-1:0]   entry,
    output logic                         hit
);

    localparam logic [CW-1:0] IDX = CW'(INDEX);

    logic [ols_pkg::DATA_W-1:0] entry_reg;
    logic [ols_pkg::DATA_W-1:0] entry_next;
    logic                       hit_reg;
    logic                       hit_next;

    always_comb
    begin
        unique case (ctrl.op)
            ols_pkg::CELL_HOLD:   entry_next = entry_reg;
            ols_pkg::CELL_PUSH:   entry_next = below_entry;
            ols_pkg::CELL_APPEND: entry_next = (IDX == count) ? value : entry_reg;
            ols_pkg::CELL_CLOSE:  entry_next = (IDX >= pos) ? above_entry : entry_reg;
            default:              entry_next = entry_reg;
        endcase
    end

    always_comb
    begin
        unique case (ctrl.hit_op)
            ols_pkg::HIT_LOAD:  hit_next = (IDX < count) && (entry_reg == value);
            ols_pkg::HIT_SHIFT: hit_next = above_hit;
            default:            hit_next = hit_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        hit_reg   <= hit_next;
    end

    assign entry = entry_reg;
    assign hit   = hit_reg;

endmodule

// ----- rtl/ols_ctrl.sv -----
// Request sequencer for the list: length, orientation, match scan and result word.
// Depends on ols_pkg; drives the row of ols_cell instances.
`timescale 1ns / 1ps

module ols_ctrl #(
    parameter int CAPACITY = ols_pkg::CAPACITY_DEFAULT,
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ols_pkg::REQ_W-1:0]         s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ols_pkg::OUT_DATA_W-1:0]    m_tdata,
    input  logic                              front_hit,
    output ols_pkg::cell_ctrl_t               cell_ctrl,
    output logic [CW-1:0]                     count,
    output logic [CW-1:0]                     pos
);

    localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE        = CW'(1);

    ols_pkg::state_t        state_reg, state_next;
    ols_pkg::req_t          req_in;
    ols_pkg::req_t          kind_reg, kind_next;
    ols_pkg::status_t       status_sel;
    logic [CW-1:0]          count_reg, count_next;
    logic [CW-1:0]          k_reg, k_next;
    logic [CW-1:0]          pos_reg, pos_next;
    logic                   found_reg, found_next;
    logic                   rev_reg, rev_next;
    logic                   out_valid_reg, out_valid_next;
    logic [ols_pkg::OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic                   out_free;
    logic                   accept;
    logic                   scan_stop;
    logic                   load_out;

    assign req_in   = ols_pkg::req_t'(s_tuser);
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ols_pkg::ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    assign scan_stop = ((k_reg + ONE) == count_reg) ||
                       (front_hit && ((kind_reg == ols_pkg::REQ_SEARCH) || !rev_reg));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ols_pkg::ST_IDLE:
            begin
                if (accept && (count_reg != '0) &&
                    ((req_in == ols_pkg::REQ_SEARCH) || (req_in == ols_pkg::REQ_DELETE)))
                begin
                    state_next = ols_pkg::ST_SCAN;
                end
            end
            ols_pkg::ST_SCAN:
            begin
                if (scan_stop)
                begin
                    state_next = ols_pkg::ST_COMMIT;
                end
            end
            ols_pkg::ST_COMMIT:
            begin
                if (out_free)
                begin
                    state_next = ols_pkg::ST_IDLE;
                end
            end
            default: state_next = ols_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cell_ctrl.op     = ols_pkg::CELL_HOLD;
        cell_ctrl.hit_op = ols_pkg::HIT_HOLD;
        count_next       = count_reg;
        k_next           = k_reg;
        pos_next         = pos_reg;
        found_next       = found_reg;
        rev_next         = rev_reg;
        kind_next        = kind_reg;
        status_sel       = ols_pkg::STS_DONE;
        load_out         = 1'b0;

        unique case (state_reg)
            ols_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    cell_ctrl.hit_op = ols_pkg::HIT_LOAD;
                    kind_next        = req_in;
                    k_next           = '0;
                    found_next       = 1'b0;
                    unique case (req_in)
                        ols_pkg::REQ_INSERT:
                        begin
                            load_out = 1'b1;
                            if (count_reg == FULL_COUNT)
                            begin
                                status_sel = ols_pkg::STS_FULL;
                            end
                            else
                            begin
                                cell_ctrl.op = rev_reg ? ols_pkg::CELL_APPEND
                                                       : ols_pkg::CELL_PUSH;
                                count_next   = count_reg + ONE;
                            end
                        end
                        ols_pkg::REQ_REVERSE:
                        begin
                            load_out = 1'b1;
                            rev_next = !rev_reg;
                        end
                        ols_pkg::REQ_SEARCH:
                        begin
                            if (count_reg == '0)
                            begin
                                load_out   = 1'b1;
                                status_sel = ols_pkg::STS_NOT_FOUND;
                            end
                        end
                        ols_pkg::REQ_DELETE:
                        begin
                            if (count_reg == '0)
                            begin
                                load_out   = 1'b1;
                                status_sel = ols_pkg::STS_EMPTY;
                            end
                        end
                        default: load_out = 1'b0;
                    endcase
                end
            end
            ols_pkg::ST_SCAN:
            begin
                cell_ctrl.hit_op = ols_pkg::HIT_SHIFT;
                k_next           = k_reg + ONE;
                if (front_hit)
                begin
                    found_next = 1'b1;
                    pos_next   = k_reg;
                end
            end
            ols_pkg::ST_COMMIT:
            begin
                if (out_free)
                begin
                    load_out = 1'b1;
                    if (kind_reg == ols_pkg::REQ_SEARCH)
                    begin
                        status_sel = found_reg ? ols_pkg::STS_FOUND : ols_pkg::STS_NOT_FOUND;
                    end
                    else if (found_reg)
                    begin
                        cell_ctrl.op = ols_pkg::CELL_CLOSE;
                        count_next   = count_reg - ONE;
                        status_sel   = ols_pkg::STS_DONE;
                    end
                    else
                    begin
                        status_sel = ols_pkg::STS_NOT_FOUND;
                    end
                end
            end
            default: load_out = 1'b0;
        endcase

        out_data_next  = load_out ? {ols_pkg::LEN_W'(count_next), status_sel} : out_data_reg;
        out_valid_next = load_out ? 1'b1 : (out_valid_reg && !m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ols_pkg::ST_IDLE;
            count_reg     <= '0;
            rev_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rev_reg       <= rev_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        k_reg        <= k_next;
        pos_reg      <= pos_next;
        found_reg    <= found_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign count    = count_reg;
    assign pos      = pos_reg;

endmodule

// ----- rtl/ordered_list_search_delete.sv -----
// Top level of the ordered list store: sequencer plus a row of CAPACITY cells.
// Depends on ols_pkg, ols_ctrl and ols_cell.
`timescale 1ns / 1ps

// Holds up to CAPACITY signed 32-bit values in a row of cells, cell 0 at one end,
// with an orientation flag marking which end is the front of the list. Insert and
// reverse finish in the cycle the request word is taken: insert shifts the row or
// writes the cell after the last entry, reverse flips the orientation flag. Search
// and delete on a non-empty list load a match bit in every cell, then walk those
// bits down the row one cell per cycle in the scan state, up to L cells for a
// length L (a search, or a delete with the front at cell 0, stops at the first
// match; a delete with the front at the far end walks all L cells), then answer
// from the commit state once the output register is free. Search or delete on an
// empty list answers without a scan. The result word sits in an output register;
// a new request is taken once the sequencer is idle and the output register is
// empty or its word leaves in the same cycle, so a stalled result holds off the
// next request. length carries the low five bits of the entry count.
module ordered_list_search_delete #(
    parameter int CAPACITY = ols_pkg::CAPACITY_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ols_pkg::DATA_W-1:0]     s_tdata,   // [31:0] value
    input  logic [ols_pkg::REQ_W-1:0]      s_tuser,   // [1:0] req_type
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ols_pkg::OUT_DATA_W-1:0] m_tdata    // [2:0] status, [7:3] length
);

    localparam int CW = $clog2(CAPACITY + 1);

    ols_pkg::cell_ctrl_t        cell_ctrl;
    logic [CW-1:0]              count;
    logic [CW-1:0]              pos;
    logic [ols_pkg::DATA_W-1:0] entries [CAPACITY];
    logic                       hits    [CAPACITY];

    ols_ctrl #(
        .CAPACITY (CAPACITY),
        .CW       (CW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .front_hit (hits[0]),
        .cell_ctrl (cell_ctrl),
        .count     (count),
        .pos       (pos)
    );

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [ols_pkg::DATA_W-1:0] below_entry;
        logic [ols_pkg::DATA_W-1:0] above_entry;
        logic                       above_hit;

        if (g == 0)
        begin : g_first
            assign below_entry = s_tdata;
        end
        else
        begin : g_rest
            assign below_entry = entries[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign above_entry = entries[g];
            assign above_hit   = 1'b0;
        end
        else
        begin : g_inner
            assign above_entry = entries[g+1];
            assign above_hit   = hits[g+1];
        end

        ols_cell #(
            .CW    (CW),
            .INDEX (g)
        ) u_cell (
            .clk         (clk),
            .ctrl        (cell_ctrl),
            .count       (count),
            .pos         (pos),
            .value       (s_tdata),
            .below_entry (below_entry),
            .above_entry (above_entry),
            .above_hit   (above_hit),
            .entry       (entries[g]),
            .hit         (hits[g])
        );
    end

endmodule

// ----- tb/ols_list_scoreboard.sv -----
// Scoreboard for the ordered list store: a predictor of the list held by the block
// and a queue of expected reply words. Depends on ols_pkg.
`timescale 1ns / 1ps

package ols_list_scoreboard_pkg;

    import ols_pkg::*;

    typedef struct packed {
        status_t          status;
        logic [LEN_W-1:0] length;
    } reply_t;

    class list_scoreboard;

        int                  capacity;
        logic [DATA_W-1:0]   cells [];
        int                  count;
        reply_t              replies [$];
        int                  errors;
        int                  req_seen [4];
        int                  status_seen [5];

        function new(int cap);
            capacity = cap;
            cells    = new[cap];
            count    = 0;
            errors   = 0;
            foreach (req_seen[i])
                req_seen[i] = 0;
            foreach (status_seen[i])
                status_seen[i] = 0;
        endfunction

        // Advance the predicted list by one accepted request word.
        function void note_request(req_t req, logic [DATA_W-1:0] key);
            reply_t            r;
            int                pos;
            int                lo;
            int                hi;
            logic [DATA_W-1:0] t;
            pos = -1;
            for (int i = 0; i < count; i++)
                if (pos < 0 && cells[i] == key)
                    pos = i;
            case (req)
                REQ_INSERT:
                begin
                    if (count >= capacity)
                        r.status = STS_FULL;
                    else
                    begin
                        for (int i = count; i > 0; i--)
                            cells[i] = cells[i-1];
                        cells[0] = key;
                        count++;
                        r.status = STS_DONE;
                    end
                end
                REQ_SEARCH:
                    r.status = (pos >= 0) ? STS_FOUND : STS_NOT_FOUND;
                REQ_DELETE:
                begin
                    if (count == 0)
                        r.status = STS_EMPTY;
                    else if (pos >= 0)
                    begin
                        for (int i = pos; i + 1 < count; i++)
                            cells[i] = cells[i+1];
                        count--;
                        r.status = STS_DONE;
                    end
                    else
                        r.status = STS_NOT_FOUND;
                end
                default:
                begin
                    lo = 0;
                    hi = count - 1;
                    while (lo < hi)
                    begin
                        t         = cells[lo];
                        cells[lo] = cells[hi];
                        cells[hi] = t;
                        lo++;
                        hi--;
                    end
                    r.status = STS_DONE;
                end
            endcase
            r.length = LEN_W'(count);
            req_seen[req]++;
            status_seen[r.status]++;
            replies.push_back(r);
        endfunction

        // Compare one accepted reply word with the oldest expectation.
        function void check_reply(logic [OUT_DATA_W-1:0] word);
            reply_t exp_r;
            if (replies.size() == 0)
            begin
                $display("%0t: unexpected reply word, actual status %0d length %0d",
                         $time, word[STATUS_W-1:0], word[STATUS_W +: LEN_W]);
                errors++;
                return;
            end
            exp_r = replies.pop_front();
            if (word[STATUS_W-1:0] !== exp_r.status)
            begin
                $display("%0t: status mismatch, expected %0d actual %0d",
                         $time, exp_r.status, word[STATUS_W-1:0]);
                errors++;
            end
            if (word[STATUS_W +: LEN_W] !== exp_r.length)
            begin
                $display("%0t: length mismatch, expected %0d actual %0d",
                         $time, exp_r.length, word[STATUS_W +: LEN_W]);
                errors++;
            end
        endfunction

        function int pending();
            return replies.size();
        endfunction

    endclass

endpackage

// ----- tb/ordered_list_search_delete_tb.sv -----
// Self-checking testbench for ordered_list_search_delete: directed and random
// requests under bursty input and stalling output. Depends on ols_pkg and
// ols_list_scoreboard_pkg.
`timescale 1ns / 1ps

module ordered_list_search_delete_tb;

    import ols_pkg::*;
    import ols_list_scoreboard_pkg::*;

    localparam int CAPACITY     = CAPACITY_DEFAULT;
    localparam int RANDOM_ITEMS = 1700;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 3 * CAPACITY + 10;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [DATA_W-1:0]     s_tdata;
    logic [REQ_W-1:0]      s_tuser;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    list_scoreboard sb = new(CAPACITY);

    int idle_cycles = 0;
    int rx_cycle    = 0;
    int rx_mode     = 0;
    int rx_stall    = 0;

    logic [DATA_W-1:0] key_pool [8] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000,
                                         32'h7FFF_FFFF, 32'h0000_0001, 32'h5555_5555,
                                         32'hAAAA_AAAA, 32'h0000_002A};

    ordered_list_search_delete #(
        .CAPACITY(CAPACITY)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),   // [31:0] value
        .s_tuser (s_tuser),   // [1:0] req_type
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)    // [2:0] status, [7:3] length
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Monitor both sides and watch for a hang.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_reply(m_tdata);
            if (s_tvalid && s_tready)
                sb.note_request(req_t'(s_tuser), s_tdata);
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no word accepted for %0d cycles", $time, IDLE_LIMIT);
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Receiver back-pressure: one of four patterns, chosen at random by rx_mode.
    always @(posedge clk)
    begin
        rx_cycle++;
        if (rx_cycle % 128 == 0)
            rx_mode = $urandom_range(0, 3);
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= (rx_cycle % 3 == 0);
            default:
            begin
                if (rx_stall > 0)
                begin
                    rx_stall--;
                    m_tready <= 1'b0;
                end
                else
                begin
                    if ($urandom_range(0, 15) == 0)
                        rx_stall = $urandom_range(8, 20);
                    m_tready <= 1'b1;
                end
            end
        endcase
    end

    // Present one request word and hold it until accepted.
    task automatic send_req(req_t req, logic [DATA_W-1:0] key);
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= key;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic pause(int n);
        if (n > 0)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom;
            repeat (n) @(posedge clk);
        end
    endtask

    function automatic logic [DATA_W-1:0] pick_key();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4 && sb.count > 0)
            return sb.cells[$urandom_range(0, sb.count - 1)];
        else if (sel < 7)
            return key_pool[$urandom_range(0, 7)];
        else
            return $urandom;
    endfunction

    // Request mix: phases 0-2 weight the four kinds out of 10, phase 3 is uniform.
    function automatic req_t pick_req(int phase);
        int r;
        r = $urandom_range(0, 9);
        case (phase)
            0: return (r < 7) ? REQ_INSERT : (r < 8) ? REQ_SEARCH :
                      (r < 9) ? REQ_DELETE : REQ_REVERSE;
            1: return (r < 2) ? REQ_INSERT : (r < 4) ? REQ_SEARCH :
                      (r < 9) ? REQ_DELETE : REQ_REVERSE;
            2: return (r < 3) ? REQ_INSERT : (r < 7) ? REQ_SEARCH :
                      (r < 9) ? REQ_DELETE : REQ_REVERSE;
            default: return req_t'($urandom_range(0, 3));
        endcase
    endfunction

    initial
    begin
        int sent;
        int burst;
        int phase;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser  <= REQ_INSERT;
        s_tdata  <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty list, extremes, duplicates, fill to full.
        send_req(REQ_SEARCH,  32'h0000_0001);
        send_req(REQ_DELETE,  32'h0000_0001);
        send_req(REQ_REVERSE, 32'h0000_0000);
        send_req(REQ_INSERT,  32'h8000_0000);
        send_req(REQ_REVERSE, 32'hFFFF_FFFF);
        send_req(REQ_INSERT,  32'h7FFF_FFFF);
        send_req(REQ_INSERT,  32'h0000_0000);
        send_req(REQ_INSERT,  32'hFFFF_FFFF);
        send_req(REQ_INSERT,  32'h7FFF_FFFF);
        send_req(REQ_SEARCH,  32'hFFFF_FFFF);
        send_req(REQ_SEARCH,  32'h0000_0001);
        send_req(REQ_REVERSE, 32'h0000_0000);
        send_req(REQ_DELETE,  32'h7FFF_FFFF);
        send_req(REQ_DELETE,  32'h0000_0005);
        send_req(REQ_SEARCH,  32'h7FFF_FFFF);
        for (int i = 0; i < CAPACITY - 4; i++)
            send_req(REQ_INSERT, 32'h0000_0100 + i);
        send_req(REQ_INSERT,  32'hDEAD_0000);
        send_req(REQ_SEARCH,  32'h8000_0000);
        send_req(REQ_DELETE,  32'h8000_0000);

        // Random: phases of growth, shrinkage, lookup and a flat mix.
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (sent % 100 == 0)
                phase = $urandom_range(0, 3);
            burst = $urandom_range(1, 24);
            for (int i = 0; i < burst && sent < RANDOM_ITEMS; i++)
            begin
                send_req(pick_req(phase), pick_key());
                sent++;
            end
            if ($urandom_range(0, 3) != 0)
                pause($urandom_range(1, ($urandom_range(0, 7) == 0) ? 30 : 6));
        end
        s_tvalid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Requests: %0d insert, %0d search, %0d delete, %0d reverse.",
                 sb.req_seen[REQ_INSERT], sb.req_seen[REQ_SEARCH],
                 sb.req_seen[REQ_DELETE], sb.req_seen[REQ_REVERSE]);
        $display("Replies: %0d done, %0d found, %0d not found, %0d empty, %0d full.",
                 sb.status_seen[STS_DONE], sb.status_seen[STS_FOUND],
                 sb.status_seen[STS_NOT_FOUND], sb.status_seen[STS_EMPTY],
                 sb.status_seen[STS_FULL]);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- ordered_list_search_delete.f -----
rtl/ols_pkg.sv
rtl/ols_cell.sv
rtl/ols_ctrl.sv
rtl/ordered_list_search_delete.sv
tb/ols_list_scoreboard.sv
tb/ordered_list_search_delete_tb.sv
